/* src/scca_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scca_pkg: shared types and helpers for the serial clock command block
// Parser modes, command characters, digit counts, the result word and the
// decimal/BCD helper functions.
// ---------------------------------------------------------------------------
package scca_pkg;

	// Parser modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_TIME  = 2'd1;
	localparam logic [1:0] MODE_ALARM = 2'd2;
	localparam logic [1:0] MODE_TERM  = 2'd3;

	// Word types on the input channel
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TIME = 1'b1;

	// Command characters
	localparam logic [7:0] CHAR_SET_TIME  = 8'h58;  // 'X'
	localparam logic [7:0] CHAR_SET_ALARM = 8'h59;  // 'Y'

	localparam int TimeDigits  = 16;
	localparam int AlarmDigits = 6;
	localparam int CountW      = 5;
	localparam int IdxW        = $clog2(TimeDigits);

	localparam logic [CountW-1:0] TIME_LAST  = CountW'(TimeDigits - 1);
	localparam logic [CountW-1:0] ALARM_LAST = CountW'(AlarmDigits - 1);

	typedef logic [3:0] nibble_t;

	typedef struct packed {
		logic       set_time;
		logic [7:0] year_bcd;
		logic [7:0] month_bcd;
		logic [7:0] day_bcd;
		logic [7:0] hour_bcd;
		logic [7:0] minute_bcd;
		logic [7:0] second_bcd;
		logic [7:0] weekday_bcd;
		logic       alarm_fire;
		logic       chime;
	} result_t;

	// Two decimal digits to a value: hi*10 + lo (at most 165)
	function automatic logic [7:0] pair_val(input nibble_t hi, input nibble_t lo);
		logic [7:0] hi10;
		hi10 = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0};
		pair_val = hi10 + {4'd0, lo};
	endfunction

	// Binary to BCD, kept to 8 bits; v/10 by reciprocal multiply (exact below 1029)
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  tens;
		logic [7:0]  tens10;
		logic [7:0]  ones;
		prod   = {8'd0, v} * 16'd205;
		tens   = prod[15:11];
		tens10 = {tens[4:0], 3'b000} + {2'b00, tens[4:0], 1'b0};
		ones   = v - tens10;
		to_bcd = {tens[3:0], 4'b0000} + ones;
	endfunction

endpackage

/* src/scca_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scca_if: channel interfaces for the serial clock command block
// Input channel carries serial bytes and time reports; output channel carries
// one result word per input word. Both use valid/ready handshakes.
// ---------------------------------------------------------------------------
interface scca_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	logic [4:0] now_hour;
	logic [5:0] now_minute;
	logic [5:0] now_second;

	modport source (output valid, op, rx_byte, now_hour, now_minute, now_second,
		input ready);
	modport sink (input valid, op, rx_byte, now_hour, now_minute, now_second,
		output ready);
endinterface

interface scca_out_if;
	logic       valid;
	logic       ready;
	logic       set_time;
	logic [7:0] year_bcd;
	logic [7:0] month_bcd;
	logic [7:0] day_bcd;
	logic [7:0] hour_bcd;
	logic [7:0] minute_bcd;
	logic [7:0] second_bcd;
	logic [7:0] weekday_bcd;
	logic       alarm_fire;
	logic       chime;

	modport source (output valid, set_time, year_bcd, month_bcd, day_bcd, hour_bcd,
		minute_bcd, second_bcd, weekday_bcd, alarm_fire, chime, input ready);
	modport sink (input valid, set_time, year_bcd, month_bcd, day_bcd, hour_bcd,
		minute_bcd, second_bcd, weekday_bcd, alarm_fire, chime, output ready);
endinterface

/* src/serial_clock_command_and_alarm_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_clock_command_and_alarm_top: command parser, alarm and chime
// Parses set-time ('X' + 16 digits + terminator) and set-alarm ('Y' + 6 digits
// + terminator) commands from serial bytes and checks time reports against
// the armed alarm and the hourly chime.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per serial byte (op = 0) or per time report (op = 1).
//   out_ch : exactly one result word for every accepted input word, in order.
//            On the last digit of a set-time command set_time is high with the
//            new values in BCD; on a time report alarm_fire and chime report
//            the match. All other fields are zero.
// Output: the result is in the output register in the cycle after acceptance.
// Throughput: one word per cycle while out_ch drains; all parsing, pair
//   combining and BCD conversion is one combinational stage before result_q.
// Stall: the input is taken whenever the output register is empty or being
//   drained in the same cycle.
// Reset: parser idle, digit count zero, alarm cleared and disarmed, no result
//   pending. The digit store is not cleared; every digit is written before
//   the pairs that use it are read.
// ---------------------------------------------------------------------------
module serial_clock_command_and_alarm_top (
	input  logic          clk,
	input  logic          arst_n,
	scca_in_if.sink       in_ch,
	scca_out_if.source    out_ch
);
	import scca_pkg::*;

	logic [1:0]        mode_q;
	logic [CountW-1:0] digit_count_q;
	nibble_t           digit_store_q [TimeDigits];
	logic [7:0]        alarm_hour_q;
	logic [7:0]        alarm_minute_q;
	logic [7:0]        alarm_second_q;
	logic              alarm_armed_q;
	logic              out_valid_q;
	result_t           result_q;

	logic              in_acc;
	nibble_t           nib;
	nibble_t           digit_view [TimeDigits];
	logic              store_wr;
	logic              time_done;
	logic              alarm_done;
	logic              fire_c;
	logic [1:0]        mode_d;
	logic [CountW-1:0] count_d;
	result_t           result_d;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign nib         = in_ch.rx_byte[3:0];

	// Store contents with the digit arriving now bypassed in
	always_comb begin
		for (int i = 0; i < TimeDigits; i++) begin
			digit_view[i] = (IdxW'(i) == digit_count_q[IdxW-1:0]) ? nib : digit_store_q[i];
		end
	end

	// Parser and alarm next-state and result
	always_comb begin
		mode_d     = mode_q;
		count_d    = digit_count_q;
		store_wr   = 1'b0;
		time_done  = 1'b0;
		alarm_done = 1'b0;
		fire_c     = 1'b0;
		result_d   = '0;
		if (in_ch.op == OP_TIME) begin
			fire_c = alarm_armed_q
				&& alarm_hour_q == {3'b000, in_ch.now_hour}
				&& alarm_minute_q == {2'b00, in_ch.now_minute}
				&& alarm_second_q == {2'b00, in_ch.now_second};
			result_d.alarm_fire = fire_c;
			result_d.chime = (in_ch.now_minute == 6'd0) && (in_ch.now_second == 6'd0);
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (in_ch.rx_byte == CHAR_SET_TIME) begin
						mode_d  = MODE_TIME;
						count_d = '0;
					end else if (in_ch.rx_byte == CHAR_SET_ALARM) begin
						mode_d  = MODE_ALARM;
						count_d = '0;
					end
				end
				MODE_TIME: begin
					store_wr = 1'b1;
					if (digit_count_q == TIME_LAST) begin
						time_done = 1'b1;
						mode_d    = MODE_TERM;
						count_d   = '0;
					end else begin
						count_d = digit_count_q + 1'b1;
					end
				end
				MODE_ALARM: begin
					store_wr = 1'b1;
					if (digit_count_q == ALARM_LAST) begin
						alarm_done = 1'b1;
						mode_d     = MODE_TERM;
						count_d    = '0;
					end else begin
						count_d = digit_count_q + 1'b1;
					end
				end
				MODE_TERM: begin
					mode_d  = MODE_IDLE;
					count_d = '0;
				end
				default: begin
					mode_d  = MODE_IDLE;
					count_d = '0;
				end
			endcase
			if (time_done) begin
				result_d.set_time    = 1'b1;
				result_d.year_bcd    = to_bcd(pair_val(digit_view[2], digit_view[3]));
				result_d.month_bcd   = to_bcd(pair_val(digit_view[4], digit_view[5]));
				result_d.day_bcd     = to_bcd(pair_val(digit_view[6], digit_view[7]));
				result_d.hour_bcd    = to_bcd(pair_val(digit_view[8], digit_view[9]));
				result_d.minute_bcd  = to_bcd(pair_val(digit_view[10], digit_view[11]));
				result_d.second_bcd  = to_bcd(pair_val(digit_view[12], digit_view[13]));
				result_d.weekday_bcd = to_bcd(pair_val(digit_view[14], digit_view[15]));
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			digit_count_q  <= '0;
			alarm_hour_q   <= '0;
			alarm_minute_q <= '0;
			alarm_second_q <= '0;
			alarm_armed_q  <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				out_valid_q   <= 1'b1;
				mode_q        <= mode_d;
				digit_count_q <= count_d;
				if (alarm_done) begin
					alarm_hour_q   <= pair_val(digit_view[0], digit_view[1]);
					alarm_minute_q <= pair_val(digit_view[2], digit_view[3]);
					alarm_second_q <= pair_val(digit_view[4], digit_view[5]);
					alarm_armed_q  <= 1'b1;
				end else if (fire_c) begin
					alarm_armed_q <= 1'b0;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit store and result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= result_d;
			if (store_wr) begin
				digit_store_q[digit_count_q[IdxW-1:0]] <= nib;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.set_time    = result_q.set_time;
	assign out_ch.year_bcd    = result_q.year_bcd;
	assign out_ch.month_bcd   = result_q.month_bcd;
	assign out_ch.day_bcd     = result_q.day_bcd;
	assign out_ch.hour_bcd    = result_q.hour_bcd;
	assign out_ch.minute_bcd  = result_q.minute_bcd;
	assign out_ch.second_bcd  = result_q.second_bcd;
	assign out_ch.weekday_bcd = result_q.weekday_bcd;
	assign out_ch.alarm_fire  = result_q.alarm_fire;
	assign out_ch.chime       = result_q.chime;

	// Checks
	a_count_zero_outside_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE || mode_q == MODE_TERM) |-> digit_count_q == '0)
		else $error("digit count nonzero outside a digit phase");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q < CountW'(TimeDigits))
		else $error("digit count beyond the store");

	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fire_c) |=> !alarm_armed_q && out_ch.valid && out_ch.alarm_fire)
		else $error("alarm fired but stayed armed");

	a_set_time_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.set_time) |-> !out_ch.alarm_fire && !out_ch.chime)
		else $error("set_time together with time report flags");

endmodule

/* dv/serial_clock_command_and_alarm_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_clock_command_and_alarm_top_test: self-checking bench for the block
// A short table of directed words (idle noise, set-alarm with a report in the
// middle, alarm plus chime, set-time with out-of-range digits) is followed by
// random command sequences, time reports and noise. Each accepted word is run
// through a local predictor, and every result word is checked in order.
// ---------------------------------------------------------------------------
module serial_clock_command_and_alarm_top_test;
	import scca_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_WORDS   = 1120;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} serial_word_t;

	typedef struct {
		serial_word_t w;
		logic         typed;
		result_t      res;
	} table_row_t;

	// Results that can be read straight off the command stream
	localparam result_t NO_RESULT  = '0;
	localparam result_t CHIME_ONLY = '{chime: 1'b1, default: '0};
	localparam result_t FIRE_CHIME = '{alarm_fire: 1'b1, chime: 1'b1, default: '0};
	localparam result_t ALL_05     = '{set_time: 1'b1, year_bcd: 8'h05, month_bcd: 8'h05,
		day_bcd: 8'h05, hour_bcd: 8'h05, minute_bcd: 8'h05, second_bcd: 8'h05,
		weekday_bcd: 8'h05, default: '0};

	logic clk = 1'b0;
	logic arst_n;

	scca_in_if  in_ch ();
	scca_out_if out_ch ();

	serial_clock_command_and_alarm_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	// Predictor state
	logic [1:0] cmd_mode;
	logic [4:0] cmd_digits;
	logic [3:0] nib_store [16];
	logic [7:0] alm_h, alm_m, alm_s;
	logic       alm_armed;

	result_t pending_results [$];
	table_row_t stim_table [$];

	int src_gap_pct  = 0;
	int sink_gap_pct = 0;
	int n_sent       = 0;
	int n_results    = 0;
	int n_set_time   = 0;
	int n_fire       = 0;
	int n_chime      = 0;
	int n_errors     = 0;
	int idle_cycles  = 0;

	// Alarm time last armed by the stimulus, used to aim reports at it
	int goal_h = 0, goal_m = 0, goal_s = 0;

	function automatic serial_word_t byte_word(input logic [7:0] b);
		serial_word_t w;
		w = '0;
		w.op = OP_BYTE;
		w.rx_byte = b;
		return w;
	endfunction

	function automatic serial_word_t time_word(input int h, input int m, input int s);
		serial_word_t w;
		w = '0;
		w.op = OP_TIME;
		w.hour = 5'(h);
		w.minute = 6'(m);
		w.second = 6'(s);
		return w;
	endfunction

	function automatic logic [7:0] digit_byte(input int d);
		return 8'h30 + 8'(d);
	endfunction

	function automatic table_row_t row(input serial_word_t w, input logic typed,
		input result_t res);
		table_row_t r;
		r.w = w;
		r.typed = typed;
		r.res = res;
		return r;
	endfunction

	// Decimal to BCD, wrapped to 8 bits
	function automatic logic [7:0] bcd_of(input logic [7:0] v);
		int b;
		b = (int'(v) / 10) * 16 + int'(v) % 10;
		return 8'(b);
	endfunction

	// Pair k of the kept nibbles as hi*10 + lo
	function automatic logic [7:0] pair_of(input int k);
		int v;
		v = int'(nib_store[(2 * k) % 16]) * 10 + int'(nib_store[(2 * k + 1) % 16]);
		return 8'(v);
	endfunction

	// Advance the predictor by one accepted word and return its result
	function automatic result_t predict_clock_word(input serial_word_t w);
		result_t r;
		r = '0;
		if (w.op == OP_TIME) begin
			if (alm_armed && alm_h == {3'b000, w.hour} && alm_m == {2'b00, w.minute}
				&& alm_s == {2'b00, w.second}) begin
				r.alarm_fire = 1'b1;
				alm_armed = 1'b0;
			end
			r.chime = (w.minute == 6'd0 && w.second == 6'd0);
			return r;
		end
		case (cmd_mode)
			MODE_IDLE: begin
				if (w.rx_byte == CHAR_SET_TIME) begin
					cmd_mode = MODE_TIME;
					cmd_digits = '0;
				end else if (w.rx_byte == CHAR_SET_ALARM) begin
					cmd_mode = MODE_ALARM;
					cmd_digits = '0;
				end
			end
			MODE_TIME, MODE_ALARM: begin
				nib_store[cmd_digits[3:0]] = w.rx_byte[3:0];
				cmd_digits = cmd_digits + 5'd1;
				if (cmd_mode == MODE_TIME && int'(cmd_digits) >= TimeDigits) begin
					r.set_time = 1'b1;
					r.year_bcd = bcd_of(pair_of(1));
					r.month_bcd = bcd_of(pair_of(2));
					r.day_bcd = bcd_of(pair_of(3));
					r.hour_bcd = bcd_of(pair_of(4));
					r.minute_bcd = bcd_of(pair_of(5));
					r.second_bcd = bcd_of(pair_of(6));
					r.weekday_bcd = bcd_of(pair_of(7));
					cmd_mode = MODE_TERM;
					cmd_digits = '0;
				end else if (cmd_mode == MODE_ALARM && int'(cmd_digits) >= AlarmDigits) begin
					alm_h = pair_of(0);
					alm_m = pair_of(1);
					alm_s = pair_of(2);
					alm_armed = 1'b1;
					cmd_mode = MODE_TERM;
					cmd_digits = '0;
				end
			end
			default: begin
				cmd_mode = MODE_IDLE;
				cmd_digits = '0;
			end
		endcase
		return r;
	endfunction

	function automatic string show_result(input result_t r);
		return $sformatf("st=%b yr=%h mo=%h dy=%h hr=%h mi=%h se=%h wd=%h fire=%b chime=%b",
			r.set_time, r.year_bcd, r.month_bcd, r.day_bcd, r.hour_bcd, r.minute_bcd,
			r.second_bcd, r.weekday_bcd, r.alarm_fire, r.chime);
	endfunction

	// Time report: often on the armed time, often on the hour
	function automatic serial_word_t rand_report();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return time_word(goal_h, goal_m, goal_s);
		if (pick < 55)
			return time_word($urandom_range(23), 0, 0);
		return time_word($urandom_range(23), $urandom_range(59), $urandom_range(59));
	endfunction

	// Offer one word, with random gaps before it, and log its expected result
	task automatic send_word(input serial_word_t w, input logic typed = 1'b0,
		input result_t res = '0);
		result_t predicted;
		while ($urandom_range(99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= w.op;
		in_ch.rx_byte <= w.rx_byte;
		in_ch.now_hour <= w.hour;
		in_ch.now_minute <= w.minute;
		in_ch.now_second <= w.second;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predicted = predict_clock_word(w);
		pending_results.push_back(typed ? res : predicted);
		n_sent++;
	endtask

	// Mostly well-formed commands with random content, plus reports and noise
	task automatic run_random(input int quota);
		int done;
		int i;
		logic [7:0] b;
		logic [7:0] al_bytes [6];
		done = 0;
		while (done < quota) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					send_word(byte_word(CHAR_SET_TIME));
					for (i = 0; i < TimeDigits; i++) begin
						if ($urandom_range(11) == 0) begin
							send_word(rand_report());
							done++;
						end
						if ($urandom_range(6) == 0)
							b = 8'($urandom_range(255));
						else
							b = digit_byte($urandom_range(9));
						send_word(byte_word(b));
					end
					send_word(byte_word(8'($urandom_range(255))));
					done += TimeDigits + 2;
				end
				3, 4, 5: begin
					if ($urandom_range(4) != 0) begin
						goal_h = $urandom_range(23);
						goal_m = ($urandom_range(3) == 0) ? 0 : $urandom_range(59);
						goal_s = (goal_m == 0 && $urandom_range(1) == 0) ? 0 : $urandom_range(59);
						al_bytes[0] = digit_byte(goal_h / 10);
						al_bytes[1] = digit_byte(goal_h % 10);
						al_bytes[2] = digit_byte(goal_m / 10);
						al_bytes[3] = digit_byte(goal_m % 10);
						al_bytes[4] = digit_byte(goal_s / 10);
						al_bytes[5] = digit_byte(goal_s % 10);
					end else begin
						for (i = 0; i < AlarmDigits; i++)
							al_bytes[i] = 8'($urandom_range(255));
					end
					send_word(byte_word(CHAR_SET_ALARM));
					for (i = 0; i < AlarmDigits; i++) begin
						if ($urandom_range(9) == 0) begin
							send_word(rand_report());
							done++;
						end
						send_word(byte_word(al_bytes[i]));
					end
					send_word(byte_word(8'($urandom_range(255))));
					done += AlarmDigits + 2;
					if ($urandom_range(1) == 0) begin
						send_word(time_word(goal_h, goal_m, goal_s));
						done++;
					end
				end
				6, 7, 8: begin
					send_word(rand_report());
					done++;
				end
				default: begin
					// Idle noise is dropped by the parser and not counted
					do
						b = 8'($urandom_range(255));
					while (b == CHAR_SET_TIME || b == CHAR_SET_ALARM);
					send_word(byte_word(b));
				end
			endcase
		end
	endtask

	// Receiver: random stalls, in-order check against the expected results
	always @(posedge clk) begin
		result_t got;
		result_t want;
		out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{set_time: out_ch.set_time, year_bcd: out_ch.year_bcd,
				month_bcd: out_ch.month_bcd, day_bcd: out_ch.day_bcd,
				hour_bcd: out_ch.hour_bcd, minute_bcd: out_ch.minute_bcd,
				second_bcd: out_ch.second_bcd, weekday_bcd: out_ch.weekday_bcd,
				alarm_fire: out_ch.alarm_fire, chime: out_ch.chime};
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result word: %s", show_result(got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("result %0d mismatch\n  expected %s\n  actual   %s",
							n_results, show_result(want), show_result(got));
				end
				n_results++;
				n_set_time += int'(want.set_time);
				n_fire += int'(want.alarm_fire);
				n_chime += int'(want.chime);
			end
		end
	end

	// Watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("serial_clock_command_and_alarm_top_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_BYTE;
		in_ch.rx_byte <= 8'h00;
		in_ch.now_hour <= 5'd0;
		in_ch.now_minute <= 6'd0;
		in_ch.now_second <= 6'd0;

		cmd_mode = MODE_IDLE;
		cmd_digits = '0;
		for (i = 0; i < 16; i++)
			nib_store[i] = 4'h0;
		alm_h = 8'h00;
		alm_m = 8'h00;
		alm_s = 8'h00;
		alm_armed = 1'b0;

		// Directed table
		// report at 00:00:00 chimes, the cleared alarm must not fire
		stim_table.push_back(row(time_word(0, 0, 0), 1'b1, CHIME_ONLY));
		// noise in idle
		stim_table.push_back(row(byte_word(8'hFF), 1'b1, NO_RESULT));
		stim_table.push_back(row(byte_word(8'h00), 1'b1, NO_RESULT));
		// alarm at 12:00:00 with a report in the middle of the digits
		stim_table.push_back(row(byte_word(CHAR_SET_ALARM), 1'b1, NO_RESULT));
		stim_table.push_back(row(byte_word(digit_byte(1)), 1'b0, NO_RESULT));
		stim_table.push_back(row(byte_word(digit_byte(2)), 1'b0, NO_RESULT));
		stim_table.push_back(row(time_word(23, 59, 59), 1'b1, NO_RESULT));
		for (i = 0; i < 4; i++)
			stim_table.push_back(row(byte_word(digit_byte(0)), 1'b0, NO_RESULT));
		// a command character as terminator is only consumed
		stim_table.push_back(row(byte_word(CHAR_SET_TIME), 1'b1, NO_RESULT));
		// alarm and chime together, then the alarm is spent
		stim_table.push_back(row(time_word(12, 0, 0), 1'b1, FIRE_CHIME));
		stim_table.push_back(row(time_word(12, 0, 0), 1'b1, CHIME_ONLY));
		// set-time with all-ones bytes: every pair is 165, BCD wraps to 05
		stim_table.push_back(row(byte_word(CHAR_SET_TIME), 1'b1, NO_RESULT));
		for (i = 0; i < TimeDigits - 1; i++)
			stim_table.push_back(row(byte_word(8'hFF), 1'b0, NO_RESULT));
		stim_table.push_back(row(byte_word(8'hFF), 1'b1, ALL_05));
		stim_table.push_back(row(byte_word(CHAR_SET_ALARM), 1'b1, NO_RESULT));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_pct = 16;
		sink_gap_pct = 52;
		foreach (stim_table[k])
			send_word(stim_table[k].w, stim_table[k].typed, stim_table[k].res);
		run_random(RANDOM_WORDS / 3);

		src_gap_pct = 52;
		sink_gap_pct = 16;
		run_random(RANDOM_WORDS / 3);

		src_gap_pct = 0;
		sink_gap_pct = 0;
		run_random(RANDOM_WORDS / 3);
		in_ch.valid <= 1'b0;

		// Drain, then a few quiet cycles to catch stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d words in, %0d results checked: %0d time sets, %0d alarms, %0d chimes",
			n_sent, n_results, n_set_time, n_fire, n_chime);
		$display("stalls: sender-light/receiver-heavy, swapped, then back-to-back");
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("serial_clock_command_and_alarm_top_test: clean");
		end else begin
			$display("%0d failures, %0d results outstanding", n_errors, pending_results.size());
			$display("serial_clock_command_and_alarm_top_test: errors");
		end
		$finish;
	end

endmodule

/* serial_clock_command_and_alarm_top.f */
src/scca_pkg.sv
src/scca_if.sv
src/serial_clock_command_and_alarm_top.sv
dv/serial_clock_command_and_alarm_top_test.sv
